[design/wafbp_pkg.sv]
// Package: shared types and constants of the wear-aware free-block pool.
`default_nettype none

package wafbp_pkg;

   // Field widths of the request and response transfers
   localparam int ACTION_W = 3;
   localparam int BLOCK_W  = 8;
   localparam int TAG_W    = 4;
   localparam int POOL_W   = 9;
   localparam int WEAR_W   = 16;

   // Saturation limit of an erase count
   localparam logic [WEAR_W-1:0] WEAR_MAX = '1;

   // Request action codes
   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT    = 3'd0,
      ACT_TAKE_LOW  = 3'd1,
      ACT_TAKE_HIGH = 3'd2,
      ACT_ERASE     = 3'd3,
      ACT_QUERY     = 3'd4
   } action_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW,
      ST_PICK,
      ST_SHIFT,
      ST_QUERY,
      ST_DONE
   } state_type;

   // One response item
   typedef struct packed {
      logic [BLOCK_W-1:0] taken_block;
      logic               empty_error;
      logic [POOL_W-1:0]  pool_size;
      logic [WEAR_W-1:0]  wear_spread;
      logic [BLOCK_W-1:0] coldest_block;
   } result_type;

endpackage

`default_nettype wire

[design/wafbp_req_if.sv]
// Interface: request channel of the free-block pool.
`default_nettype none

interface wafbp_req_if;
   logic                             valid;
   logic                             ready;
   logic [wafbp_pkg::ACTION_W-1:0]   action;
   logic [wafbp_pkg::BLOCK_W-1:0]    block_index;
   logic                             key_by_wear;
   logic [wafbp_pkg::TAG_W-1:0]      stream_tag;

   modport source (output valid, action, block_index, key_by_wear, stream_tag,
                   input ready);
   modport sink   (input valid, action, block_index, key_by_wear, stream_tag,
                   output ready);
endinterface

`default_nettype wire

[design/wafbp_rsp_if.sv]
// Interface: response channel of the free-block pool.
`default_nettype none

interface wafbp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [wafbp_pkg::BLOCK_W-1:0]   taken_block;
   logic                            empty_error;
   logic [wafbp_pkg::POOL_W-1:0]    pool_size;
   logic [wafbp_pkg::WEAR_W-1:0]    wear_spread;
   logic [wafbp_pkg::BLOCK_W-1:0]   coldest_block;

   modport source (output valid, taken_block, empty_error, pool_size, wear_spread,
                   coldest_block, input ready);
   modport sink   (input valid, taken_block, empty_error, pool_size, wear_spread,
                   coldest_block, output ready);
endinterface

`default_nettype wire

[design/wafbp_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module wafbp_ram #(
   parameter int  DEPTH  = 256,
   parameter int  WIDTH  = 41,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/wafbp_ctrl.sv]
// Sequencer: clears the block table, runs read-modify-write and scan passes.
`default_nettype none

module wafbp_ctrl #(
   parameter int  BLOCKS = 256,
   localparam int IDX_W  = $clog2(BLOCKS),
   localparam int CNT_W  = $clog2(BLOCKS + 1),
   localparam int WORD_W = 2 * wafbp_pkg::WEAR_W + 1 + IDX_W
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   wafbp_req_if.sink                 req,
   output logic                      res_valid,
   input  wire logic                 res_ack,
   output wafbp_pkg::result_type     res_data,
   output logic                      mem_wr_en,
   output logic [IDX_W-1:0]          mem_wr_addr,
   output logic [WORD_W-1:0]         mem_wr_data,
   output logic                      mem_rd_en,
   output logic [IDX_W-1:0]          mem_rd_addr,
   input  wire logic [WORD_W-1:0]    mem_rd_data
);

   import wafbp_pkg::*;

   // table word: {erase count, pooled, key, rank}
   logic [WEAR_W-1:0] rd_ecnt;
   logic              rd_pool;
   logic [WEAR_W-1:0] rd_key;
   logic [IDX_W-1:0]  rd_ord;

   assign rd_ecnt = mem_rd_data[WORD_W-1 -: WEAR_W];
   assign rd_pool = mem_rd_data[IDX_W + WEAR_W];
   assign rd_key  = mem_rd_data[IDX_W +: WEAR_W];
   assign rd_ord  = mem_rd_data[IDX_W-1:0];

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]  pipe_idx_ff, pipe_idx_in;
   action_type        act_ff, act_in;
   logic [IDX_W-1:0]  blk_ff, blk_in;
   logic              wear_ff, wear_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              best_vld_ff, best_vld_in;
   logic [WEAR_W-1:0] best_key_ff, best_key_in;
   logic [IDX_W-1:0]  best_ord_ff, best_ord_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [WEAR_W-1:0] mx_ff, mx_in;
   logic [WEAR_W-1:0] mn_ff, mn_in;
   logic [IDX_W-1:0]  mn_idx_ff, mn_idx_in;
   result_type        res_ff, res_in;

   logic       req_act_rmw;
   logic       req_blk_ok;
   action_type req_act;
   logic       issue;
   logic       scan_last;
   logic       better;

   assign req_act    = action_type'(req.action);
   assign req_blk_ok = int'(req.block_index) < BLOCKS;
   assign req_act_rmw = (req_act == ACT_INSERT) || (req_act == ACT_ERASE);

   // scan pass: a read goes out per cycle, its data comes back in the cycle after
   assign issue     = cnt_ff != CNT_W'(BLOCKS);
   assign scan_last = pipe_vld_ff && (pipe_idx_ff == IDX_W'(BLOCKS - 1));

   // pick order: key first, then rank
   always_comb begin
      if (!best_vld_ff) begin
         better = 1'b1;
      end else if (act_ff == ACT_TAKE_HIGH) begin
         better = (rd_key > best_key_ff) ||
                  ((rd_key == best_key_ff) && (rd_ord > best_ord_ff));
      end else begin
         better = (rd_key < best_key_ff) ||
                  ((rd_key == best_key_ff) && (rd_ord < best_ord_ff));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == CNT_W'(BLOCKS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req.valid) begin
               case (req_act)
                  ACT_INSERT, ACT_ERASE: state_in = req_blk_ok ? ST_RMW : ST_DONE;
                  ACT_TAKE_LOW, ACT_TAKE_HIGH:
                     state_in = (count_ff == '0) ? ST_DONE : ST_PICK;
                  ACT_QUERY: state_in = ST_QUERY;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_RMW:   state_in = ST_DONE;
         ST_PICK:  if (scan_last) state_in = ST_SHIFT;
         ST_SHIFT: if (scan_last) state_in = ST_DONE;
         ST_QUERY: if (scan_last) state_in = ST_DONE;
         ST_DONE:  if (res_ack) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req.ready   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = cnt_ff[IDX_W-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = pipe_idx_ff;
      mem_wr_data = mem_rd_data;
      cnt_in      = cnt_ff;
      pipe_vld_in = 1'b0;
      pipe_idx_in = cnt_ff[IDX_W-1:0];
      act_in      = act_ff;
      blk_in      = blk_ff;
      wear_in     = wear_ff;
      count_in    = count_ff;
      best_vld_in = best_vld_ff;
      best_key_in = best_key_ff;
      best_ord_in = best_ord_ff;
      best_idx_in = best_idx_ff;
      mx_in       = mx_ff;
      mn_in       = mn_ff;
      mn_idx_in   = mn_idx_ff;
      res_in      = res_ff;

      case (state_ff)
         // clearing pass: every block pooled, key zero, rank = index
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff[IDX_W-1:0];
            mem_wr_data = {{WEAR_W{1'b0}}, 1'b1, {WEAR_W{1'b0}}, cnt_ff[IDX_W-1:0]};
            cnt_in      = cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               act_in      = req_act;
               blk_in      = IDX_W'(req.block_index);
               wear_in     = req.key_by_wear;
               cnt_in      = '0;
               best_vld_in = 1'b0;
               mem_rd_en   = req_act_rmw && req_blk_ok;
               mem_rd_addr = IDX_W'(req.block_index);
               res_in      = '0;
               res_in.pool_size = POOL_W'(count_ff);
               if (((req_act == ACT_TAKE_LOW) || (req_act == ACT_TAKE_HIGH)) &&
                   (count_ff == '0)) begin
                  res_in.empty_error = 1'b1;
               end
            end
         end
         // insert or erase of one block
         ST_RMW: begin
            mem_wr_addr = blk_ff;
            if (act_ff == ACT_INSERT) begin
               if (!rd_pool) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = {rd_ecnt, 1'b1, (wear_ff ? rd_ecnt : {WEAR_W{1'b0}}),
                                 count_ff[IDX_W-1:0]};
                  count_in    = count_ff + 1'b1;
               end
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_data = {((rd_ecnt == WEAR_MAX) ? rd_ecnt : rd_ecnt + 1'b1),
                              rd_pool, rd_key, rd_ord};
            end
            res_in.pool_size = POOL_W'(count_in);
         end
         // first pass: find the entry to take
         ST_PICK: begin
            mem_rd_en   = issue;
            pipe_vld_in = issue;
            if (issue) cnt_in = cnt_ff + 1'b1;
            if (pipe_vld_ff && rd_pool && better) begin
               best_vld_in = 1'b1;
               best_key_in = rd_key;
               best_ord_in = rd_ord;
               best_idx_in = pipe_idx_ff;
            end
            if (scan_last) cnt_in = '0;
         end
         // second pass: unpool the taken entry, close the rank gap
         ST_SHIFT: begin
            mem_rd_en   = issue;
            pipe_vld_in = issue;
            if (issue) cnt_in = cnt_ff + 1'b1;
            if (pipe_vld_ff) begin
               mem_wr_en = 1'b1;
               if (pipe_idx_ff == best_idx_ff) begin
                  mem_wr_data = {rd_ecnt, 1'b0, rd_key, {IDX_W{1'b0}}};
               end else if (rd_pool && (rd_ord > best_ord_ff)) begin
                  mem_wr_data = {rd_ecnt, rd_pool, rd_key, rd_ord - 1'b1};
               end
            end
            if (scan_last) begin
               count_in             = count_ff - 1'b1;
               res_in.taken_block   = BLOCK_W'(best_idx_ff);
               res_in.pool_size     = POOL_W'(count_in);
            end
         end
         // wear query: max, min and first index of min
         ST_QUERY: begin
            mem_rd_en   = issue;
            pipe_vld_in = issue;
            if (issue) cnt_in = cnt_ff + 1'b1;
            if (pipe_vld_ff) begin
               if (pipe_idx_ff == '0) begin
                  mx_in     = rd_ecnt;
                  mn_in     = rd_ecnt;
                  mn_idx_in = '0;
               end else begin
                  if (rd_ecnt > mx_ff) mx_in = rd_ecnt;
                  if (rd_ecnt < mn_ff) begin
                     mn_in     = rd_ecnt;
                     mn_idx_in = pipe_idx_ff;
                  end
               end
            end
            if (scan_last) begin
               res_in.wear_spread   = mx_in - mn_in;
               res_in.coldest_block = BLOCK_W'(mn_idx_in);
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign res_valid = (state_ff == ST_DONE);
   assign res_data  = res_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         cnt_ff      <= '0;
         pipe_vld_ff <= 1'b0;
         count_ff    <= CNT_W'(BLOCKS);
         best_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         pipe_vld_ff <= pipe_vld_in;
         count_ff    <= count_in;
         best_vld_ff <= best_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pipe_idx_ff <= pipe_idx_in;
      act_ff      <= act_in;
      blk_ff      <= blk_in;
      wear_ff     <= wear_in;
      best_key_ff <= best_key_in;
      best_ord_ff <= best_ord_in;
      best_idx_ff <= best_idx_in;
      mx_ff       <= mx_in;
      mn_ff       <= mn_in;
      mn_idx_ff   <= mn_idx_in;
      res_ff      <= res_in;
   end

endmodule

`default_nettype wire

[design/wear_aware_free_block_pool.sv]
// Top level: wear-aware free-block pool with one block table and a response register.
//
// Usage:
//   req_ch carries one action per transfer: insert, take lowest, take highest,
//   erase or wear query. rsp_ch returns exactly one response per request.
//   One request is in work at a time; a new one is taken as soon as the
//   sequencer is idle, even while the previous response waits in rsp_ch.
// Work done per request before the response is valid:
//   insert / erase      : read, write back
//   take (pool non-empty): two passes over the table
//   wear query          : one pass over the table
//   others, empty take  : no table access
//   Scan speed is set by the single read port of the block table: one entry
//   is read per cycle during a scan.
// Reset: synchronous, active high. Afterwards a clearing pass writes every entry
//   (pooled, key zero, rank = index, erase count zero); req_ch.ready stays low
//   during that pass.
// Stall: a response is held in rsp_ch until taken; a finished request then
//   waits in the sequencer, and no further request is accepted meanwhile.
`default_nettype none

module wear_aware_free_block_pool #(
   parameter int BLOCKS = 256
) (
   input wire logic   clock,
   input wire logic   reset,
   wafbp_req_if.sink  req_ch,
   wafbp_rsp_if.source rsp_ch
);

   import wafbp_pkg::*;

   localparam int IDX_W  = $clog2(BLOCKS);
   localparam int WORD_W = 2 * WEAR_W + 1 + IDX_W;

   logic              res_valid;
   logic              res_ack;
   result_type        res_data;
   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic [WORD_W-1:0] mem_rd_data;

   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_data_ff, rsp_data_in;

   // sequencer
   wafbp_ctrl #(
      .BLOCKS (BLOCKS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .res_valid   (res_valid),
      .res_ack     (res_ack),
      .res_data    (res_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // block table
   wafbp_ram #(
      .DEPTH (BLOCKS),
      .WIDTH (WORD_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // response register
   assign res_ack = !rsp_vld_ff || rsp_ch.ready;

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (res_valid && res_ack) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = res_data;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.taken_block   = rsp_data_ff.taken_block;
   assign rsp_ch.empty_error   = rsp_data_ff.empty_error;
   assign rsp_ch.pool_size     = rsp_data_ff.pool_size;
   assign rsp_ch.wear_spread   = rsp_data_ff.wear_spread;
   assign rsp_ch.coldest_block = rsp_data_ff.coldest_block;

endmodule

`default_nettype wire

[bench/tb.sv]
// Testbench: free-block pool driven over its request channel, responses checked against a mirror.
`default_nettype none

module tb;
   import wafbp_pkg::*;

   localparam int BLOCKS          = 256;
   localparam int ACT_CODE_MAX    = (1 << ACTION_W) - 1;
   localparam int GAP_MAX         = 11;
   localparam int WEAR_UP_ERASES  = 200;
   localparam int RANDOM_ITEMS    = 1600;
   localparam int HOT_BASE        = 40;
   localparam int HOT_SPAN        = 8;
   localparam int HOLD_AT_RSP     = 60;
   localparam int HOLD_CYCLES     = 1500;
   localparam int QUIET_LIMIT     = 10000;
   localparam int SETTLE_CYCLES   = 2 * BLOCKS + 16;

   // Mirror of the pool: erase counts, pool membership, keys and insertion stamps.
   // Stream tags never reach a response, so they are not kept.
   class free_pool_mirror;
      logic [WEAR_W-1:0] wear [BLOCKS];
      bit                pooled [BLOCKS];
      logic [WEAR_W-1:0] pool_key [BLOCKS];
      int unsigned       stamp [BLOCKS];
      int unsigned       next_stamp;
      int                pool_count;
      result_type        awaited[$];
      int                mismatches;

      function new();
         for (int i = 0; i < BLOCKS; i++) begin
            wear[i]     = '0;
            pooled[i]   = 1'b1;
            pool_key[i] = '0;
            stamp[i]    = i;
         end
         next_stamp = BLOCKS;
         pool_count = BLOCKS;
         mismatches = 0;
      endfunction

      // Lowest key with oldest stamp, or highest key with newest stamp; -1 when empty
      function int pick_block(bit highest);
         int best;
         best = -1;
         for (int i = 0; i < BLOCKS; i++) begin
            if (!pooled[i]) continue;
            if (best < 0) begin
               best = i;
            end else if (highest) begin
               if (pool_key[i] > pool_key[best] ||
                   (pool_key[i] == pool_key[best] && stamp[i] > stamp[best]))
                  best = i;
            end else begin
               if (pool_key[i] < pool_key[best] ||
                   (pool_key[i] == pool_key[best] && stamp[i] < stamp[best]))
                  best = i;
            end
         end
         return best;
      endfunction

      // Apply one accepted request and queue the response it must produce
      function void log_request(logic [ACTION_W-1:0] act, logic [BLOCK_W-1:0] blk,
                                bit by_wear);
         result_type exp;
         int b, mn, mx;
         exp = '0;
         case (act)
            ACT_INSERT: begin
               // an insert of a block already in the pool changes nothing
               if (!pooled[blk]) begin
                  pool_key[blk] = by_wear ? wear[blk] : '0;
                  stamp[blk]    = next_stamp;
                  next_stamp++;
                  pooled[blk]   = 1'b1;
                  pool_count++;
               end
            end
            ACT_TAKE_LOW, ACT_TAKE_HIGH: begin
               b = pick_block(act == ACT_TAKE_HIGH);
               if (b < 0) begin
                  exp.empty_error = 1'b1;
               end else begin
                  pooled[b] = 1'b0;
                  pool_count--;
                  exp.taken_block = b[BLOCK_W-1:0];
               end
            end
            ACT_ERASE: begin
               // saturating count; the pool key of a pooled block is untouched
               if (wear[blk] != WEAR_MAX) wear[blk]++;
            end
            ACT_QUERY: begin
               mn = 0;
               mx = 0;
               for (int i = 1; i < BLOCKS; i++) begin
                  if (wear[i] > wear[mx]) mx = i;
                  if (wear[i] < wear[mn]) mn = i;
               end
               exp.wear_spread   = wear[mx] - wear[mn];
               exp.coldest_block = mn[BLOCK_W-1:0];
            end
            default: ;
         endcase
         exp.pool_size = pool_count[POOL_W-1:0];
         awaited.push_back(exp);
      endfunction

      function void compare(string field, logic [WEAR_W-1:0] exp, logic [WEAR_W-1:0] got);
         if (got !== exp) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp, got);
            mismatches++;
         end
      endfunction

      function void check_response(result_type got);
         result_type exp;
         if (awaited.size() == 0) begin
            $display("%0t: response with nothing outstanding, expected none, got %p",
                     $time, got);
            mismatches++;
            return;
         end
         exp = awaited.pop_front();
         compare("taken_block", WEAR_W'(exp.taken_block), WEAR_W'(got.taken_block));
         compare("empty_error", WEAR_W'(exp.empty_error), WEAR_W'(got.empty_error));
         compare("pool_size", WEAR_W'(exp.pool_size), WEAR_W'(got.pool_size));
         compare("wear_spread", exp.wear_spread, got.wear_spread);
         compare("coldest_block", WEAR_W'(exp.coldest_block), WEAR_W'(got.coldest_block));
      endfunction
   endclass

   logic            clock;
   logic            reset = 1'b1;
   bit              no_idle = 1'b0;
   int              responses_seen = 0;
   free_pool_mirror pool;

   wafbp_req_if req_ch();
   wafbp_rsp_if rsp_ch();

   wear_aware_free_block_pool #(.BLOCKS(BLOCKS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   // Random block outside the pool, -1 when all are pooled
   function automatic int random_unpooled();
      int n, pick;
      n = BLOCKS - pool.pool_count;
      if (n == 0) return -1;
      pick = $urandom_range(0, n - 1);
      for (int i = 0; i < BLOCKS; i++) begin
         if (!pool.pooled[i]) begin
            if (pick == 0) return i;
            pick--;
         end
      end
      return -1;
   endfunction

   // One request transfer, after a random gap; valid stays up when there is no gap
   task automatic issue_request(input logic [ACTION_W-1:0] act,
                                input logic [BLOCK_W-1:0]  blk,
                                input bit                  by_wear,
                                input logic [TAG_W-1:0]    tag);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.action      = act;
      req_ch.block_index = blk;
      req_ch.key_by_wear = by_wear;
      req_ch.stream_tag  = tag;
      req_ch.valid       = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pool.log_request(act, blk, by_wear);
   endtask

   // Response side: random stalls, one long hold-off to back the block up
   initial begin : response_side
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = draw_gap();
         if (responses_seen == HOLD_AT_RSP) stall = HOLD_CYCLES;
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         pool.check_response({rsp_ch.taken_block, rsp_ch.empty_error, rsp_ch.pool_size,
                              rsp_ch.wear_spread, rsp_ch.coldest_block});
         responses_seen++;
      end
   end

   // Watchdog on cycles without any transfer
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int                  done, fill_to, pick, r, sat_block;
      bit                  draining, by_wear;
      logic [ACTION_W-1:0] act;
      logic [BLOCK_W-1:0]  blk;
      logic [TAG_W-1:0]    tag;

      pool               = new();
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_INSERT;
      req_ch.block_index = '0;
      req_ch.key_by_wear = 1'b0;
      req_ch.stream_tag  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: fresh state, ignored insert, tie order, erase of a pooled block,
      // key by wear against key zero, unknown actions
      issue_request(ACT_QUERY, '0, 1'b0, '0);
      issue_request(ACT_INSERT, 8'd17, 1'b1, '0);
      issue_request(ACT_TAKE_LOW, '1, 1'b1, '1);
      issue_request(ACT_TAKE_HIGH, '0, 1'b0, '0);
      repeat (3) issue_request(ACT_ERASE, '0, 1'b0, '1);
      issue_request(ACT_ERASE, '1, 1'b1, '0);
      issue_request(ACT_ERASE, 8'd17, 1'b0, '0);
      issue_request(ACT_INSERT, '0, 1'b1, '0);
      issue_request(ACT_INSERT, '1, 1'b0, '1);
      issue_request(ACT_QUERY, '1, 1'b1, '1);
      issue_request(ACT_TAKE_HIGH, '0, 1'b0, 4'd9);
      issue_request(ACT_TAKE_HIGH, '0, 1'b0, '1);
      issue_request(ACT_TAKE_LOW, '0, 1'b0, '0);
      issue_request(ACT_TAKE_LOW, '0, 1'b0, 4'd6);
      issue_request(ACT_INSERT, 8'd17, 1'b1, '0);
      issue_request(ACT_INSERT, 8'd1, 1'b1, '0);
      issue_request(ACT_TAKE_LOW, '0, 1'b0, '0);
      for (int a = ACT_QUERY + 1; a <= ACT_CODE_MAX; a++)
         issue_request(a[ACTION_W-1:0], '1, 1'b1, '1);
      issue_request(ACT_QUERY, '0, 1'b0, '0);

      // Wear one block well above the rest, then pool it at the top key
      sat_block = random_unpooled();
      no_idle   = 1'b1;
      repeat (WEAR_UP_ERASES)
         issue_request(ACT_ERASE, sat_block[BLOCK_W-1:0], 1'b0, TAG_W'($urandom));
      no_idle = 1'b0;
      issue_request(ACT_QUERY, '0, 1'b0, '0);
      issue_request(ACT_INSERT, sat_block[BLOCK_W-1:0], 1'b1, '0);
      issue_request(ACT_TAKE_HIGH, '0, 1'b0, '1);
      issue_request(ACT_INSERT, sat_block[BLOCK_W-1:0], 1'b1, '0);

      // Random: alternate drain phases (down to empty) and fill phases
      draining = 1'b1;
      fill_to  = BLOCKS;
      done     = 0;
      while (done < RANDOM_ITEMS) begin
         if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
         r       = $urandom_range(0, 99);
         blk     = BLOCK_W'($urandom);
         by_wear = 1'($urandom_range(0, 1));
         tag     = TAG_W'($urandom);
         if (draining ? r < 70 : r < 10) begin
            act = $urandom_range(0, 1) ? ACT_TAKE_HIGH : ACT_TAKE_LOW;
         end else if (draining ? r < 78 : r < 60) begin
            act  = ACT_INSERT;
            pick = random_unpooled();
            if (pick >= 0 && $urandom_range(0, 4) != 0) blk = pick[BLOCK_W-1:0];
         end else if (draining ? r < 88 : r < 80) begin
            act = ACT_ERASE;
            // a few hot blocks so that keys and wear spread grow apart
            if ($urandom_range(0, 2) != 0)
               blk = BLOCK_W'(HOT_BASE + $urandom_range(0, HOT_SPAN - 1));
         end else if (r < 95) begin
            act = ACT_QUERY;
         end else begin
            act = ACTION_W'($urandom_range(ACT_QUERY + 1, ACT_CODE_MAX));
         end
         if (!(act == ACT_INSERT && pool.pooled[blk])) done++;
         issue_request(act, blk, by_wear, tag);
         if (draining && pool.pool_count == 0 && $urandom_range(0, 3) == 0) begin
            draining = 1'b0;
            fill_to  = $urandom_range(BLOCKS / 2, BLOCKS);
         end else if (!draining && pool.pool_count >= fill_to) begin
            draining = 1'b1;
         end
      end
      no_idle = 1'b0;

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pool.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pool.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
